// ===== src/srt_pkg.sv =====
// Package for the row table with per-category counters.
// Opcodes, status codes, sizes and the response struct; no dependencies.
package srt_pkg;
   localparam int MAX_ROWS       = 256;
   localparam int MAX_CATEGORIES = 16;
   localparam int ROW_W          = $clog2(MAX_ROWS);
   localparam int CAT_W          = $clog2(MAX_CATEGORIES);
   localparam int CNT_ADDR_W     = ROW_W + CAT_W;

   localparam logic [2:0] OP_FIND   = 3'd0;
   localparam logic [2:0] OP_SET    = 3'd1;
   localparam logic [2:0] OP_CLRID  = 3'd2;
   localparam logic [2:0] OP_CLRROW = 3'd3;
   localparam logic [2:0] OP_CLAIM  = 3'd4;
   localparam logic [2:0] OP_ADD    = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NOTFOUND = 3'd1;
   localparam logic [2:0] ST_RANGE    = 3'd2;
   localparam logic [2:0] ST_FREE     = 3'd3;
   localparam logic [2:0] ST_BADCAT   = 3'd4;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_CATS = 1'b1;

   typedef struct packed {
      logic       valid;
      logic [2:0] status;
      logic [7:0] row;
   } rsp_type;
endpackage

// ===== src/srt_counter_mem.sv =====
// Counter store: one 64-bit counter per row and category, read-modify-write.
// Depends on srt_pkg. Clears itself after reset, one entry per cycle.
module srt_counter_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          add_start,
   input  logic [srt_pkg::CNT_ADDR_W-1:0] add_addr,
   input  logic [31:0]                   add_delta,
   output logic                          add_done,
   output logic                          clear_busy
);
   import srt_pkg::*;

   logic [63:0] mem [0:MAX_ROWS*MAX_CATEGORIES-1];
   logic [63:0] rd_data_ff;
   logic [CNT_ADDR_W-1:0] addr_ff, addr_in;
   logic [31:0] delta_ff, delta_in;
   logic [1:0] phase_ff, phase_in;
   logic [CNT_ADDR_W:0] clr_ff, clr_in;
   logic we;
   logic [CNT_ADDR_W-1:0] waddr;
   logic [63:0] wdata;

   assign clear_busy = !clr_ff[CNT_ADDR_W];

   always_comb begin
      addr_in  = addr_ff;
      delta_in = delta_ff;
      phase_in = phase_ff;
      clr_in   = clr_ff;
      we       = 1'b0;
      waddr    = addr_ff;
      wdata    = rd_data_ff + {{32{delta_ff[31]}}, delta_ff};
      add_done = 1'b0;
      if (clear_busy) begin
         we     = 1'b1;
         waddr  = clr_ff[CNT_ADDR_W-1:0];
         wdata  = '0;
         clr_in = clr_ff + 1'b1;
      end else begin
         unique case (phase_ff)
            2'd0: if (add_start) begin
               addr_in  = add_addr;
               delta_in = add_delta;
               phase_in = 2'd1;
            end
            2'd1: phase_in = 2'd2;
            2'd2: begin
               we       = 1'b1;
               add_done = 1'b1;
               phase_in = 2'd0;
            end
            default: phase_in = 2'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         clr_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         clr_ff   <= clr_in;
      end
      addr_ff    <= addr_in;
      delta_ff   <= delta_in;
      rd_data_ff <= mem[addr_ff];
      if (we) mem[waddr] <= wdata;
   end
endmodule

// ===== src/stat_row_table_with_counters.sv =====
// Top level of the row table with per-category counters.
// Depends on srt_pkg and srt_counter_mem.
//
//  channel | ports                                        | flow
//  req     | start, busy, req_* fields                    | start && !busy
//  rsp     | rsp_valid, rsp_* fields                      | one cycle strobe
//  csr     | csr_valid, csr_ready, csr_index, csr_data    | valid && ready
//
// Set id, claim and range errors answer straight from dispatch; add reads the
// owner id, then reads, adds and writes the counter memory. Searches issue and
// then check each row read; a free-row search with the hint above the high mark
// reads some rows twice. A top-row clear adds a downward scan of the rows below
// it. After reset the counter memory is cleared, all 4096 entries, with busy
// high. Results cannot be stalled.
module stat_row_table_with_counters (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_row_index,
   input  logic [63:0] req_row_id,
   input  logic [7:0]  req_search_hint,
   input  logic [3:0]  req_category,
   input  logic signed [31:0] req_delta,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_result_row,
   output logic [8:0]  rsp_rows_in_use,
   output logic [8:0]  rsp_rows_peak,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);
   import srt_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DISP  = 4'd1;
   localparam logic [3:0] S_SRCH  = 4'd2;  // issue read of cur
   localparam logic [3:0] S_SCHK  = 4'd3;  // check data of cur
   localparam logic [3:0] S_DOWN  = 4'd4;
   localparam logic [3:0] S_DCHK  = 4'd5;
   localparam logic [3:0] S_ADDW  = 4'd6;
   localparam logic [3:0] S_RCHK  = 4'd7;  // add: check owner id

   logic [3:0] state_ff, state_in;
   logic [63:0] ids [0:MAX_ROWS-1];
   logic [63:0] rd_ff;
   logic [ROW_W-1:0] raddr;
   logic we;
   logic [ROW_W-1:0] waddr;
   logic [63:0] wdata;

   logic [8:0] rows_cfg_ff, rows_cfg_in;
   logic [4:0] cats_cfg_ff, cats_cfg_in;
   logic [8:0] high_ff, high_in, peak_ff, peak_in;
   logic [2:0] op_ff, op_in;
   logic [7:0] row_ff, row_in, hint_ff, hint_in;
   logic [63:0] id_ff, id_in;
   logic [3:0] cat_ff, cat_in;
   logic [31:0] delta_ff, delta_in;
   // search pass: 0 hint..high, 1 0..hint, 2 high..rows
   logic [1:0] pass_ff, pass_in;
   logic [8:0] cur_ff, cur_in;
   rsp_type rsp_ff, rsp_in;

   logic [8:0] eff_rows, eff_cats, lim;
   logic add_start, add_done, clr_busy;

   assign eff_rows = (rows_cfg_ff > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows_cfg_ff;
   assign eff_cats = ({4'd0, cats_cfg_ff} > 9'(MAX_CATEGORIES)) ? 9'(MAX_CATEGORIES)
                                                               : {4'd0, cats_cfg_ff};
   assign busy      = (state_ff != S_IDLE) || clr_busy;
   assign csr_ready = 1'b1;

   srt_counter_mem u_cnt (
      .clock(clock), .reset(reset), .add_start(add_start),
      .add_addr({row_ff[ROW_W-1:0], cat_ff[CAT_W-1:0]}),
      .add_delta(delta_ff), .add_done(add_done), .clear_busy(clr_busy)
   );

   // upper bound of the current search pass, cut at the row count
   always_comb begin
      logic [8:0] u;
      unique case (pass_ff)
         2'd0:    u = high_ff;
         2'd1:    u = {1'b0, hint_ff};
         default: u = eff_rows;
      endcase
      lim = (u > eff_rows) ? eff_rows : u;
   end

   always_comb begin
      logic in_range;
      logic [63:0] key;
      state_in = state_ff;
      rows_cfg_in = rows_cfg_ff;
      cats_cfg_in = cats_cfg_ff;
      high_in = high_ff;
      peak_in = peak_ff;
      op_in = op_ff; row_in = row_ff; hint_in = hint_ff; id_in = id_ff;
      cat_in = cat_ff; delta_in = delta_ff;
      pass_in = pass_ff;
      cur_in = cur_ff;
      rsp_in = '0;
      rsp_in.status = rsp_ff.status;
      rsp_in.row = rsp_ff.row;
      raddr = cur_ff[ROW_W-1:0];
      we = 1'b0;
      waddr = row_ff[ROW_W-1:0];
      wdata = id_ff;
      add_start = 1'b0;
      in_range = {1'b0, row_ff} < eff_rows;
      key = (op_ff == OP_FIND) ? 64'd0 : id_ff;

      if (csr_valid) begin
         if (csr_index == CSR_ROWS) rows_cfg_in = csr_data;
         else                       cats_cfg_in = csr_data[4:0];
      end

      unique case (state_ff)
         S_IDLE: if (start && !clr_busy) begin
            op_in = req_opcode; row_in = req_row_index; id_in = req_row_id;
            hint_in = req_search_hint; cat_in = req_category; delta_in = req_delta;
            state_in = S_DISP;
         end
         S_DISP: begin
            rsp_in.status = ST_OK;
            rsp_in.row = row_ff;
            pass_in = 2'd0;
            cur_in = {1'b0, hint_ff};
            priority if (op_ff == OP_FIND || op_ff == OP_CLRID) begin
               state_in = S_SRCH;
            end else if (op_ff == OP_SET || op_ff == OP_CLRROW || op_ff == OP_CLAIM
                         || op_ff == OP_ADD) begin
               if (!in_range) begin
                  rsp_in.status = ST_RANGE;
                  rsp_in.valid = 1'b1;
                  state_in = S_IDLE;
               end else if (op_ff == OP_SET) begin
                  we = 1'b1;
                  rsp_in.valid = 1'b1;
                  state_in = S_IDLE;
               end else if (op_ff == OP_CLAIM) begin
                  we = 1'b1;
                  wdata = {56'd0, row_ff};
                  if ({1'b0, row_ff} >= high_ff) begin
                     high_in = {1'b0, row_ff} + 9'd1;
                     if ({1'b0, row_ff} >= peak_ff) peak_in = {1'b0, row_ff} + 9'd1;
                  end
                  rsp_in.valid = 1'b1;
                  state_in = S_IDLE;
               end else if (op_ff == OP_CLRROW) begin
                  we = 1'b1;
                  wdata = '0;
                  if (high_ff != 9'd0 && {1'b0, row_ff} == high_ff - 9'd1) begin
                     high_in = high_ff - 9'd1;
                     cur_in = {1'b0, row_ff};
                     state_in = S_DOWN;
                  end else begin
                     rsp_in.valid = 1'b1;
                     state_in = S_IDLE;
                  end
               end else begin
                  raddr = row_ff[ROW_W-1:0];
                  state_in = S_RCHK;
               end
            end else begin
               rsp_in.row = '0;
               rsp_in.valid = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SRCH: begin
            if (cur_ff < lim) begin
               raddr = cur_ff[ROW_W-1:0];
               state_in = S_SCHK;
            end else if (pass_ff == 2'd0 && hint_ff != 8'd0) begin
               pass_in = 2'd1;
               cur_in = '0;
            end else if (op_ff == OP_FIND && pass_ff != 2'd2) begin
               pass_in = 2'd2;
               cur_in = high_ff;
            end else begin
               rsp_in.status = ST_NOTFOUND;
               rsp_in.row = '0;
               rsp_in.valid = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCHK: begin
            if (rd_ff == key) begin
               rsp_in.row = cur_ff[7:0];
               if (op_ff == OP_FIND) begin
                  if (pass_ff == 2'd2) begin
                     high_in = cur_ff + 9'd1;
                     if (cur_ff >= peak_ff) peak_in = cur_ff + 9'd1;
                  end
                  rsp_in.valid = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  we = 1'b1;
                  waddr = cur_ff[ROW_W-1:0];
                  wdata = '0;
                  if (high_ff != 9'd0 && cur_ff == high_ff - 9'd1) begin
                     high_in = high_ff - 9'd1;
                     state_in = S_DOWN;
                  end else begin
                     rsp_in.valid = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            end else begin
               cur_in = cur_ff + 9'd1;
               state_in = S_SRCH;
            end
         end
         S_DOWN: begin
            // cleared row was written last cycle; start below it
            if (cur_ff == 9'd0) begin
               rsp_in.valid = 1'b1;
               state_in = S_IDLE;
            end else begin
               cur_in = cur_ff - 9'd1;
               raddr = cur_in[ROW_W-1:0];
               state_in = S_DCHK;
            end
         end
         S_DCHK: begin
            if (rd_ff != 64'd0) begin
               high_in = cur_ff + 9'd1;
               rsp_in.valid = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_DOWN;
            end
         end
         S_RCHK: begin
            if (rd_ff == 64'd0) begin
               rsp_in.status = ST_FREE;
               rsp_in.valid = 1'b1;
               state_in = S_IDLE;
            end else if ({5'd0, cat_ff} >= eff_cats) begin
               rsp_in.status = ST_BADCAT;
               rsp_in.valid = 1'b1;
               state_in = S_IDLE;
            end else begin
               add_start = 1'b1;
               state_in = S_ADDW;
            end
         end
         S_ADDW: if (add_done) begin
            rsp_in.valid = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // owner id memory; reset clears it through valid bits
   logic [MAX_ROWS-1:0] vld_ff;
   logic [63:0] mem_q;
   logic rd_vld_ff;
   always_ff @(posedge clock) begin
      if (we) ids[waddr] <= wdata;
      mem_q <= ids[raddr];
      rd_vld_ff <= vld_ff[raddr] && !(we && waddr == raddr);
   end
   // a read in the cycle of a write to the same row returns zero
   assign rd_ff = rd_vld_ff ? mem_q : 64'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rows_cfg_ff <= 9'd256;
         cats_cfg_ff <= 5'd16;
         high_ff <= '0;
         peak_ff <= '0;
         rsp_ff <= '0;
         vld_ff <= '0;
      end else begin
         state_ff <= state_in;
         rows_cfg_ff <= rows_cfg_in;
         cats_cfg_ff <= cats_cfg_in;
         high_ff <= high_in;
         peak_ff <= peak_in;
         rsp_ff <= rsp_in;
         if (we) vld_ff[waddr] <= 1'b1;
      end
      op_ff <= op_in; row_ff <= row_in; hint_ff <= hint_in; id_ff <= id_in;
      cat_ff <= cat_in; delta_ff <= delta_in;
      pass_ff <= pass_in; cur_ff <= cur_in;
   end

   assign rsp_valid = rsp_ff.valid;
   assign rsp_status = rsp_ff.status;
   assign rsp_result_row = rsp_ff.row;
   assign rsp_rows_in_use = high_ff;
   assign rsp_rows_peak = peak_ff;
endmodule

// ===== tb/tb_stat_row_table_with_counters.sv =====
// Testbench for stat_row_table_with_counters: directed and random commands
// checked against an in-bench model of the row table. Depends on srt_pkg.
`timescale 1ns / 1ps

module tb_stat_row_table_with_counters;
   import srt_pkg::*;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] row;
      logic [8:0] used;
      logic [8:0] peak;
   } table_rsp_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_opcode;
   logic [7:0]  req_row_index;
   logic [63:0] req_row_id;
   logic [7:0]  req_search_hint;
   logic [3:0]  req_category;
   logic signed [31:0] req_delta;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_result_row;
   logic [8:0]  rsp_rows_in_use;
   logic [8:0]  rsp_rows_peak;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [8:0]  csr_data;

   // model state
   logic [63:0] owner_id [MAX_ROWS];
   int unsigned high_mark;
   int unsigned peak_mark;
   int unsigned row_cfg;
   int unsigned cat_cfg;

   table_rsp_type expected_rsp_q[$];
   int         error_count;
   bit         gaps_on;

   stat_row_table_with_counters uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("[stat_row_table_with_counters] ERROR");
      $finish;
   end

   function automatic int unsigned rows_eff();
      return (row_cfg < MAX_ROWS) ? row_cfg : MAX_ROWS;
   endfunction

   function automatic bit scan_rows(input logic [63:0] id, input int unsigned from,
                                    input int unsigned upto, output int unsigned at);
      int unsigned r;
      if (upto > rows_eff())
         upto = rows_eff();
      at = 0;
      for (r = from; r < upto; r++) begin
         if (owner_id[r] == id) begin
            at = r;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic bit hinted_scan(input logic [63:0] id, input int unsigned hint,
                                      output int unsigned at);
      if (scan_rows(id, hint, high_mark, at))
         return 1'b1;
      if (hint != 0 && scan_rows(id, 0, hint, at))
         return 1'b1;
      return 1'b0;
   endfunction

   function automatic void free_row(input int unsigned r);
      int k;
      owner_id[r] = '0;
      if (high_mark != 0 && r == high_mark - 1) begin
         high_mark--;
         // walk down to the next owned row
         for (k = int'(r); k >= 0; k--) begin
            if (owner_id[k] != '0) begin
               high_mark = k + 1;
               break;
            end
         end
      end
   endfunction

   function automatic table_rsp_type table_step(input logic [2:0] op,
                                                input logic [7:0] row,
                                                input logic [63:0] id,
                                                input logic [7:0] hint,
                                                input logic [3:0] cat);
      table_rsp_type e;
      int unsigned at;
      bit          in_range;
      in_range = row < rows_eff();
      e = '0;
      case (op)
         OP_FIND: begin
            if (hinted_scan('0, hint, at)) begin
               e.row = 8'(at);
            end else if (scan_rows('0, high_mark, rows_eff(), at)) begin
               e.row = 8'(at);
               high_mark = at + 1;
               if (at >= peak_mark)
                  peak_mark = at + 1;
            end else begin
               e.status = ST_NOTFOUND;
            end
         end
         OP_SET: begin
            e.row = row;
            if (!in_range) e.status = ST_RANGE;
            else owner_id[row] = id;
         end
         OP_CLRID: begin
            if (hinted_scan(id, hint, at)) begin
               e.row = 8'(at);
               free_row(at);
            end else begin
               e.status = ST_NOTFOUND;
            end
         end
         OP_CLRROW: begin
            e.row = row;
            if (!in_range) e.status = ST_RANGE;
            else free_row(row);
         end
         OP_CLAIM: begin
            e.row = row;
            if (!in_range) begin
               e.status = ST_RANGE;
            end else begin
               owner_id[row] = 64'(row);
               if (row >= high_mark) begin
                  high_mark = 32'(row) + 1;
                  if (row >= peak_mark)
                     peak_mark = 32'(row) + 1;
               end
            end
         end
         OP_ADD: begin
            // counter values never reach the outputs; only the checks matter
            e.row = row;
            if (!in_range) e.status = ST_RANGE;
            else if (owner_id[row] == '0) e.status = ST_FREE;
            else if (cat >= ((cat_cfg < MAX_CATEGORIES) ? cat_cfg : MAX_CATEGORIES))
               e.status = ST_BADCAT;
         end
         default: ;
      endcase
      e.used = high_mark[8:0];
      e.peak = peak_mark[8:0];
      return e;
   endfunction

   always @(posedge clock) begin
      table_rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result status=%0d row=%0d used=%0d peak=%0d", $time,
                     rsp_status, rsp_result_row, rsp_rows_in_use, rsp_rows_peak);
            error_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_status !== exp_rsp.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_rsp.status,
                        rsp_status);
               error_count++;
            end
            if (rsp_result_row !== exp_rsp.row) begin
               $display("%0t: result_row expected %0d actual %0d", $time, exp_rsp.row,
                        rsp_result_row);
               error_count++;
            end
            if (rsp_rows_in_use !== exp_rsp.used) begin
               $display("%0t: rows_in_use expected %0d actual %0d", $time, exp_rsp.used,
                        rsp_rows_in_use);
               error_count++;
            end
            if (rsp_rows_peak !== exp_rsp.peak) begin
               $display("%0t: rows_peak expected %0d actual %0d", $time, exp_rsp.peak,
                        rsp_rows_peak);
               error_count++;
            end
         end
      end
   end

   // Leaves start high; callers drop it when idling.
   task automatic send_cmd(input logic [2:0] op, input logic [7:0] row,
                           input logic [63:0] id, input logic [7:0] hint,
                           input logic [3:0] cat, input logic [31:0] delta);
      start           <= 1'b1;
      req_opcode      <= op;
      req_row_index   <= row;
      req_row_id      <= id;
      req_search_hint <= hint;
      req_category    <= cat;
      req_delta       <= delta;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsp_q.push_back(table_step(op, row, id, hint, cat));
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [8:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_ROWS) row_cfg = 32'(val);
      else cat_cfg = 32'(val[4:0]);
   endtask

   task automatic test_directed();
      send_cmd(OP_FIND, 0, 0, 0, 0, 0);
      send_cmd(OP_FIND, 0, 0, 255, 0, 0);
      send_cmd(OP_CLAIM, 200, 0, 0, 0, 0);
      send_cmd(OP_CLAIM, 255, 0, 0, 0, 0);
      send_cmd(OP_CLAIM, 0, 0, 0, 0, 0);
      send_cmd(OP_SET, 5, '1, 0, 0, 0);
      send_cmd(OP_SET, 255, 64'h8000_0000_0000_0001, 0, 0, 0);
      send_cmd(OP_CLRID, 0, '1, 200, 0, 0);
      send_cmd(OP_CLRID, 0, 64'h1234, 17, 0, 0);
      // top-row clear falls back to row 200
      send_cmd(OP_CLRROW, 255, 0, 0, 0, 0);
      send_cmd(OP_ADD, 200, 0, 0, 0, 32'h7FFF_FFFF);
      send_cmd(OP_ADD, 200, 0, 0, 15, 32'h8000_0000);
      send_cmd(OP_ADD, 3, 0, 0, 0, 1);
      send_cmd(OP_SET, 7, 0, 0, 0, 0);
      send_cmd(OP_CLRID, 0, 200, 0, 0, 0);
      send_cmd(OP_FIND, 0, 0, 100, 0, 0);
      send_cmd(3'd6, '1, '1, '1, '1, '1);
      send_cmd(3'd7, 0, 0, 0, 0, 0);
      send_cmd(OP_CLRROW, 0, 0, 0, 0, 0);
      drain();
   endtask

   task automatic test_small_config();
      csr_write(CSR_ROWS, 9'd1);
      csr_write(CSR_CATS, 9'd1);
      send_cmd(OP_SET, 0, 1, 0, 0, 0);
      send_cmd(OP_ADD, 0, 0, 0, 1, 5);
      send_cmd(OP_ADD, 0, 0, 0, 0, -5);
      send_cmd(OP_ADD, 1, 0, 0, 0, 5);
      send_cmd(OP_CLAIM, 1, 0, 0, 0, 0);
      send_cmd(OP_CLRROW, 200, 0, 0, 0, 0);
      send_cmd(OP_SET, 255, 9, 0, 0, 0);
      send_cmd(OP_FIND, 0, 0, 0, 0, 0);
      send_cmd(OP_CLRID, 0, 1, 255, 0, 0);
      send_cmd(OP_FIND, 0, 0, 255, 0, 0);
      drain();
   endtask

   task automatic send_random_cmd(input int id_pool);
      logic [2:0]  op;
      logic [7:0]  row;
      logic [63:0] id;
      logic [7:0]  hint;
      int unsigned pick;
      int unsigned lim;
      lim  = (rows_eff() > 0) ? rows_eff() - 1 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 25) op = OP_FIND;
      else if (pick < 40) op = OP_SET;
      else if (pick < 55) op = OP_CLRID;
      else if (pick < 68) op = OP_CLRROW;
      else if (pick < 78) op = OP_CLAIM;
      else if (pick < 97) op = OP_ADD;
      else op = 3'($urandom_range(6, 7));
      row  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, lim));
      hint = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, lim));
      case ($urandom_range(0, 3))
         0: id = {$urandom, $urandom};
         1: id = 64'($urandom_range(0, id_pool));
         default: id = owner_id[$urandom_range(0, lim)];
      endcase
      send_cmd(op, row, id, hint, 4'($urandom), $urandom);
      if (gaps_on && $urandom_range(0, 3) == 0)
         pause($urandom_range(1, 19));
   endtask

   task automatic test_fill_to_full();
      csr_write(CSR_ROWS, 9'd4);
      csr_write(CSR_CATS, 9'd16);
      repeat (6) send_cmd(OP_FIND, 0, 0, 8'($urandom_range(0, 3)), 0, 0);
      // hold off until the table state has settled
      drain();
      send_cmd(OP_CLRROW, 3, 0, 0, 0, 0);
      send_cmd(OP_CLRROW, 1, 0, 0, 0, 0);
      send_cmd(OP_FIND, 0, 0, 3, 0, 0);
      drain();
   endtask

   task automatic test_random(input int n, input logic [8:0] rows, input logic [8:0] cats,
                              input bit gaps);
      csr_write(CSR_ROWS, rows);
      csr_write(CSR_CATS, cats);
      gaps_on = gaps;
      repeat (n) send_random_cmd(8);
      drain();
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = '0;
      req_row_index   = '0;
      req_row_id      = '0;
      req_search_hint = '0;
      req_category    = '0;
      req_delta       = '0;
      csr_valid       = 1'b0;
      csr_index       = 1'b0;
      csr_data        = '0;
      error_count     = 0;
      gaps_on         = 1'b0;
      high_mark       = 0;
      peak_mark       = 0;
      row_cfg         = 256;
      cat_cfg         = 16;
      foreach (owner_id[i]) owner_id[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_small_config();
      test_fill_to_full();
      test_random(150, 9'd256, 9'd16, 1'b1);
      test_random(120, 9'd8, 9'd3, 1'b1);
      test_random(100, 9'd2, 9'd1, 1'b1);
      test_random(100, 9'd37, 9'd9, 1'b1);
      test_random(130, 9'd256, 9'd16, 1'b0);

      if (error_count == 0)
         $display("[stat_row_table_with_counters] OK");
      else
         $display("[stat_row_table_with_counters] ERROR");
      $finish;
   end
endmodule
